FILE: design/mp3_frame_sync_finder_macros.svh
// Assertion macros used by the checker file of the frame sync finder.
`ifndef MP3_FRAME_SYNC_FINDER_MACROS_SVH
`define MP3_FRAME_SYNC_FINDER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define MFSF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define MFSF_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define MFSF_ASSERT_ALW(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mfsf_pkg.sv
package mfsf_pkg;

    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [7:0] SYNC_NO_CRC   = 8'hFB;
    localparam logic [7:0] SYNC_WITH_CRC = 8'hFA;
    localparam logic [7:0] TAG_CHAR_I    = 8'h49;
    localparam logic [7:0] TAG_CHAR_D    = 8'h44;
    localparam logic [7:0] TAG_CHAR_3    = 8'h33;
    localparam logic [7:0] TAG_VER_LIMIT = 8'h80;
    localparam logic [6:0] SYNCSAFE_MASK = 7'h7F;

    localparam logic [3:0] KBPS_FREE      = 4'd0;
    localparam logic [3:0] KBPS_FORBIDDEN = 4'd15;
    localparam logic [1:0] HZ_RESERVED    = 2'd3;

    localparam logic [3:0] TAG_FIRST_INDEX = 4'd4;
    localparam logic [3:0] TAG_SIZE_INDEX  = 4'd6;
    localparam logic [3:0] TAG_LAST_INDEX  = 4'd9;

    localparam int OUT_DATA_W = 72;

    // Frame length in bytes, less the four header bytes, for each bit rate index.
    localparam logic [10:0] LEN_44K1 [16] = '{
        11'd0,   11'd100, 11'd126, 11'd152, 11'd178, 11'd204, 11'd257, 11'd309,
        11'd361, 11'd413, 11'd518, 11'd622, 11'd727, 11'd831, 11'd1040, 11'd0
    };
    localparam logic [10:0] LEN_48K [16] = '{
        11'd0,   11'd92,  11'd116, 11'd140, 11'd164, 11'd188, 11'd236, 11'd284,
        11'd332, 11'd380, 11'd476, 11'd572, 11'd668, 11'd764, 11'd956, 11'd0
    };
    localparam logic [10:0] LEN_32K [16] = '{
        11'd0,   11'd140, 11'd176, 11'd212, 11'd248, 11'd284, 11'd356, 11'd428,
        11'd500, 11'd572, 11'd716, 11'd860, 11'd1004, 11'd1148, 11'd1436, 11'd0
    };

    typedef struct packed {
        logic        crc_present;
        logic        padding;
        logic [15:0] sample_rate_hz;
        logic [8:0]  bit_rate_kbps;
        logic [10:0] frame_payload_len;
        logic [31:0] start_offset;
    } mfsf_result_t;

    function automatic logic [8:0] kbps_lookup(input logic [3:0] idx);
        logic [8:0] kbps;
        case (idx)
            4'd1:    kbps = 9'd32;
            4'd2:    kbps = 9'd40;
            4'd3:    kbps = 9'd48;
            4'd4:    kbps = 9'd56;
            4'd5:    kbps = 9'd64;
            4'd6:    kbps = 9'd80;
            4'd7:    kbps = 9'd96;
            4'd8:    kbps = 9'd112;
            4'd9:    kbps = 9'd128;
            4'd10:   kbps = 9'd160;
            4'd11:   kbps = 9'd192;
            4'd12:   kbps = 9'd224;
            4'd13:   kbps = 9'd256;
            4'd14:   kbps = 9'd320;
            default: kbps = 9'd0;
        endcase
        return kbps;
    endfunction

    function automatic logic [15:0] hz_lookup(input logic [1:0] idx);
        logic [15:0] hz;
        case (idx)
            2'd0:    hz = 16'd44100;
            2'd1:    hz = 16'd48000;
            2'd2:    hz = 16'd32000;
            default: hz = 16'd0;
        endcase
        return hz;
    endfunction

    function automatic logic [10:0] body_len_lookup(input logic [3:0] kidx,
                                                   input logic [1:0] sidx);
        logic [10:0] len;
        case (sidx)
            2'd0:    len = LEN_44K1[kidx];
            2'd1:    len = LEN_48K[kidx];
            2'd2:    len = LEN_32K[kidx];
            default: len = 11'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: design/mfsf_parser.sv
module mfsf_parser
    import mfsf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         item_valid,
    input  logic [7:0]   data_byte,
    input  logic         stream_start,
    output logic         res_valid,
    output mfsf_result_t res
);

    localparam logic [1:0] MODE_SEARCH = 2'd0;
    localparam logic [1:0] MODE_TAG    = 2'd1;
    localparam logic [1:0] MODE_SKIP   = 2'd2;
    localparam logic [1:0] MODE_DONE   = 2'd3;

    logic [23:0] window_reg, window_next, window_cur;
    logic [1:0]  fill_reg, fill_next, fill_cur;
    logic [1:0]  mode_reg, mode_next, mode_cur;
    logic [3:0]  tag_idx_reg, tag_idx_next, tag_idx_cur;
    logic [27:0] tag_accum_reg, tag_accum_next, tag_accum_cur;
    logic [27:0] skip_reg, skip_next, skip_cur;
    logic [31:0] pos_reg, pos_next, pos_cur;

    logic [7:0]  h0, h1, h2;
    logic [3:0]  kbps_idx;
    logic [1:0]  hz_idx;
    logic        is_sync, is_usable, is_tag, emit;
    logic [27:0] accum_upd, skip_dec;

    always_comb begin
        window_cur    = stream_start ? 24'd0 : window_reg;
        fill_cur      = stream_start ? 2'd0 : fill_reg;
        mode_cur      = stream_start ? MODE_SEARCH : mode_reg;
        tag_idx_cur   = stream_start ? 4'd0 : tag_idx_reg;
        tag_accum_cur = stream_start ? 28'd0 : tag_accum_reg;
        skip_cur      = stream_start ? 28'd0 : skip_reg;
        pos_cur       = stream_start ? 32'd0 : pos_reg;

        h0 = window_cur[23:16];
        h1 = window_cur[15:8];
        h2 = window_cur[7:0];
        kbps_idx = data_byte[7:4];
        hz_idx   = data_byte[3:2];

        is_sync   = (h0 == SYNC_BYTE) && ((h1 == SYNC_NO_CRC) || (h1 == SYNC_WITH_CRC));
        is_usable = (kbps_idx != KBPS_FREE) && (kbps_idx != KBPS_FORBIDDEN)
                    && (hz_idx != HZ_RESERVED);
        is_tag    = (h0 == TAG_CHAR_I) && (h1 == TAG_CHAR_D) && (h2 == TAG_CHAR_3)
                    && (data_byte < TAG_VER_LIMIT);

        accum_upd = {tag_accum_cur[20:0], data_byte[6:0] & SYNCSAFE_MASK};
        skip_dec  = (skip_cur != 28'd0) ? skip_cur - 28'd1 : skip_cur;

        window_next    = window_cur;
        fill_next      = fill_cur;
        mode_next      = mode_cur;
        tag_idx_next   = tag_idx_cur;
        tag_accum_next = tag_accum_cur;
        skip_next      = skip_cur;
        pos_next       = (pos_cur == '1) ? pos_cur : pos_cur + 32'd1;
        emit           = 1'b0;

        case (mode_cur)
            MODE_SEARCH: begin
                if ((fill_cur == 2'd3) && is_sync && is_usable) begin
                    emit      = 1'b1;
                    mode_next = MODE_DONE;
                end else if ((fill_cur == 2'd3) && !is_sync && is_tag) begin
                    mode_next      = MODE_TAG;
                    tag_idx_next   = TAG_FIRST_INDEX;
                    tag_accum_next = 28'd0;
                    window_next    = 24'd0;
                    fill_next      = 2'd0;
                end else begin
                    window_next = {window_cur[15:0], data_byte};
                    if (fill_cur != 2'd3) begin
                        fill_next = fill_cur + 2'd1;
                    end
                end
            end
            MODE_TAG: begin
                if (tag_idx_cur >= TAG_SIZE_INDEX) begin
                    tag_accum_next = accum_upd;
                end
                if (tag_idx_cur >= TAG_LAST_INDEX) begin
                    skip_next    = tag_accum_next;
                    tag_idx_next = 4'd0;
                    if (tag_accum_next == 28'd0) begin
                        mode_next   = MODE_SEARCH;
                        window_next = 24'd0;
                        fill_next   = 2'd0;
                    end else begin
                        mode_next = MODE_SKIP;
                    end
                end else begin
                    tag_idx_next = tag_idx_cur + 4'd1;
                end
            end
            MODE_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 28'd0) begin
                    mode_next   = MODE_SEARCH;
                    window_next = 24'd0;
                    fill_next   = 2'd0;
                end
            end
            default: begin
            end
        endcase

        res_valid             = item_valid && emit;
        res.start_offset      = pos_cur - 32'd3;
        res.frame_payload_len = body_len_lookup(kbps_idx, hz_idx) + {10'd0, data_byte[1]};
        res.bit_rate_kbps     = kbps_lookup(kbps_idx);
        res.sample_rate_hz    = hz_lookup(hz_idx);
        res.padding           = data_byte[1];
        res.crc_present       = (h1 == SYNC_WITH_CRC);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= 24'd0;
            fill_reg      <= 2'd0;
            mode_reg      <= MODE_SEARCH;
            tag_idx_reg   <= 4'd0;
            tag_accum_reg <= 28'd0;
            skip_reg      <= 28'd0;
            pos_reg       <= 32'd0;
        end else if (item_valid) begin
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            mode_reg      <= mode_next;
            tag_idx_reg   <= tag_idx_next;
            tag_accum_reg <= tag_accum_next;
            skip_reg      <= skip_next;
            pos_reg       <= pos_next;
        end
    end

endmodule

FILE: design/mp3_frame_sync_finder.sv
// Finds the first usable MPEG-1 Layer 3 frame header in a byte stream.
// Input channel: one file byte per transfer in s_tdata, with s_tuser set on
// the first byte of a new file, which clears all search state before use.
// A leading ID3v2 tag is skipped whole, using the length in its header.
// Output channel: at most one transfer per file, giving the offset of the
// sync byte, the decoded bit rate and sample rate, the padding and CRC flags
// and the frame length less the four header bytes.
// Throughput is one byte per cycle while s_tready is high: each byte is handled
// in a single pass of logic between the search state registers and the output
// stage. The result of the byte that completes the header is registered into
// the output stage and appears on m_tvalid once any result ahead of it has gone.
// After a result, further bytes only advance the position counter until the
// next s_tuser marks a new file.
// Reset clears the search state and empties the output stage; s_tready is
// low while reset is held.
// The output stage holds two results. While m_tready is low the block keeps
// taking bytes; s_tready drops only when both entries are full.
module mp3_frame_sync_finder
    import mfsf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // [7:0] data_byte
    input  logic [0:0]            s_tuser,  // [0] stream_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // [31:0] start_offset,
                                            // [42:32] frame_payload_len,
                                            // [51:43] bit_rate_kbps,
                                            // [67:52] sample_rate_hz,
                                            // [68] padding, [69] crc_present
);

    logic         in_xfer;
    logic         res_valid;
    mfsf_result_t res;

    logic         out_valid_reg, out_valid_next;
    mfsf_result_t out_data_reg, out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    mfsf_result_t skid_data_reg, skid_data_next;

    assign s_tready = aresetn && !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;

    mfsf_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (in_xfer),
        .data_byte    (s_tdata),
        .stream_start (s_tuser[0]),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = res_valid;
                skid_data_next  = res;
            end else begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

endmodule

FILE: design/mfsf_checker.sv
`include "mp3_frame_sync_finder_macros.svh"

module mfsf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    logic unused_inputs;
    assign unused_inputs = s_tvalid ^ (^s_tdata) ^ s_tuser[0];

    `MFSF_ASSERT_ALW(a_reset_empties_output, aclk, !aresetn, !m_tvalid, "Result shown straight after reset")

    `MFSF_ASSERT_NXT(a_stalled_result_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Stalled result changed or vanished")

    `MFSF_ASSERT_IMP(a_backpressure_needs_result, aclk, aresetn, aresetn && !s_tready, m_tvalid, "Input stalled with no result waiting")

    `MFSF_ASSERT_IMP(a_result_fields_sane, aclk, aresetn, m_tvalid, ((m_tdata[67:52] == 16'd44100) || (m_tdata[67:52] == 16'd48000) || (m_tdata[67:52] == 16'd32000)) && (m_tdata[42:32] >= 11'd92) && (m_tdata[42:32] <= 11'd1437) && (m_tdata[51:43] >= 9'd32) && (m_tdata[51:43] <= 9'd320), "Result fields out of range")

endmodule

bind mp3_frame_sync_finder mfsf_checker u_mfsf_checker (.*);

FILE: sim/tb_mp3_frame_sync_finder.sv
`timescale 1ns / 100ps

module tb_mp3_frame_sync_finder;
    import mfsf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 540;
    localparam int RESULT_TARGET = 48;

    localparam int unsigned KBPS_OF [16] = '{
        0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0
    };
    localparam int unsigned HZ_OF [4] = '{44100, 48000, 32000, 0};

    typedef enum logic [1:0] {HUNTING, TAG_HEADER, TAG_BODY, LOCKED} finder_mode_e;

    class sync_scoreboard;
        mfsf_result_t expected_q[$];
        logic [23:0]  window;
        logic [1:0]   fill;
        finder_mode_e mode;
        logic [3:0]   tag_idx;
        logic [27:0]  tag_len;
        logic [27:0]  skip_left;
        logic [31:0]  pos;
        int           errors;
        int           produced;

        function new();
            clear();
            errors   = 0;
            produced = 0;
        endfunction

        function void clear();
            window    = '0;
            fill      = '0;
            mode      = HUNTING;
            tag_idx   = '0;
            tag_len   = '0;
            skip_left = '0;
            pos       = '0;
        endfunction

        function void restart_hunt();
            mode   = HUNTING;
            window = '0;
            fill   = '0;
        endfunction

        function void note_byte(input logic [7:0] b, input logic first);
            logic [31:0]  here;
            logic [3:0]   kidx;
            logic [1:0]   sidx;
            int unsigned  kbps;
            int unsigned  hz;
            logic         slide;
            mfsf_result_t r;
            if (first) begin
                clear();
            end
            here = pos;
            if (pos != '1) begin
                pos++;
            end
            kidx = b[7:4];
            sidx = b[3:2];
            case (mode)
                HUNTING: begin
                    slide = 1'b1;
                    if (fill == 2'd3) begin
                        if (window[23:16] == SYNC_BYTE &&
                            (window[15:8] == SYNC_NO_CRC || window[15:8] == SYNC_WITH_CRC)) begin
                            if (kidx != KBPS_FREE && kidx != KBPS_FORBIDDEN &&
                                sidx != HZ_RESERVED) begin
                                kbps                = KBPS_OF[kidx];
                                hz                  = HZ_OF[sidx];
                                r.start_offset      = here - 32'd3;
                                r.frame_payload_len = 11'((144000 * kbps) / hz + b[1] - 4);
                                r.bit_rate_kbps     = 9'(kbps);
                                r.sample_rate_hz    = 16'(hz);
                                r.padding           = b[1];
                                r.crc_present       = (window[15:8] == SYNC_WITH_CRC);
                                expected_q.push_back(r);
                                produced++;
                                mode  = LOCKED;
                                slide = 1'b0;
                            end
                        end else if (window == {TAG_CHAR_I, TAG_CHAR_D, TAG_CHAR_3} &&
                                     b < TAG_VER_LIMIT) begin
                            mode    = TAG_HEADER;
                            tag_idx = TAG_FIRST_INDEX;
                            tag_len = '0;
                            window  = '0;
                            fill    = '0;
                            slide   = 1'b0;
                        end
                    end
                    if (slide) begin
                        window = {window[15:0], b};
                        if (fill != 2'd3) begin
                            fill++;
                        end
                    end
                end
                TAG_HEADER: begin
                    if (tag_idx >= TAG_SIZE_INDEX) begin
                        tag_len = {tag_len[20:0], b[6:0] & SYNCSAFE_MASK};
                    end
                    if (tag_idx >= TAG_LAST_INDEX) begin
                        skip_left = tag_len;
                        tag_idx   = '0;
                        if (tag_len == '0) begin
                            restart_hunt();
                        end else begin
                            mode = TAG_BODY;
                        end
                    end else begin
                        tag_idx++;
                    end
                end
                TAG_BODY: begin
                    if (skip_left != '0) begin
                        skip_left--;
                    end
                    if (skip_left == '0) begin
                        restart_hunt();
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input logic [OUT_DATA_W-1:0] data);
            mfsf_result_t got;
            mfsf_result_t want;
            got = data[$bits(mfsf_result_t)-1:0];
            if (expected_q.size() == 0) begin
                $error("result transfer with no header pending: offset %0d", got.start_offset);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("start_offset", want.start_offset, got.start_offset);
            compare_field("frame_payload_len", want.frame_payload_len, got.frame_payload_len);
            compare_field("bit_rate_kbps", want.bit_rate_kbps, got.bit_rate_kbps);
            compare_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
            compare_field("padding", want.padding, got.padding);
            compare_field("crc_present", want.crc_present, got.crc_present);
            compare_field("m_tdata fill bits", '0, data[OUT_DATA_W-1:$bits(mfsf_result_t)]);
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    sync_scoreboard sb = new();
    logic [7:0]     stream_q[$];
    int             src_idle_pct  = 0;
    int             sink_idle_pct = 0;
    int             hold_request  = 0;
    int             bytes_sent    = 0;
    int             cycle_count   = 0;

    mp3_frame_sync_finder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** mp3_frame_sync_finder: FAILED **");
            $finish;
        end
    end

    // The sink honours a requested hold-off before going back to random stalls.
    initial begin : result_sink
        int hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.note_byte(b, first);
        bytes_sent++;
    endtask

    task automatic send_stream();
        foreach (stream_q[i]) begin
            send_byte(stream_q[i], i == 0);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (sb.expected_q.size() != 0);
    endtask

    function automatic logic [7:0] junk_byte();
        case ($urandom_range(7))
            0:       return SYNC_BYTE;
            1:       return SYNC_NO_CRC;
            2:       return SYNC_WITH_CRC;
            3:       return TAG_CHAR_I;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] good_rate_byte();
        return {4'($urandom_range(14, 1)), 2'($urandom_range(2)), 2'($urandom)};
    endfunction

    function automatic logic [7:0] bad_rate_byte();
        case ($urandom_range(2))
            0:       return {KBPS_FREE, 4'($urandom)};
            1:       return {KBPS_FORBIDDEN, 4'($urandom)};
            default: return {4'($urandom), HZ_RESERVED, 2'($urandom)};
        endcase
    endfunction

    function automatic logic [7:0] sync_second();
        return $urandom_range(1) ? SYNC_WITH_CRC : SYNC_NO_CRC;
    endfunction

    // Mostly well-formed files: junk, an optional tag, maybe an unusable header,
    // then a good header and a short tail. Some are pure noise or cut short.
    function automatic void build_stream();
        int unsigned body_len;
        stream_q.delete();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(30, 3)) stream_q.push_back(junk_byte());
            return;
        end
        repeat ($urandom_range(5)) stream_q.push_back(junk_byte());
        if ($urandom_range(2) == 0) begin
            body_len = ($urandom_range(7) == 0) ? $urandom_range(300) : $urandom_range(12);
            stream_q.push_back(TAG_CHAR_I);
            stream_q.push_back(TAG_CHAR_D);
            stream_q.push_back(TAG_CHAR_3);
            stream_q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255, 128))
                                                         : 8'($urandom_range(127)));
            stream_q.push_back(8'($urandom));
            stream_q.push_back(8'($urandom));
            stream_q.push_back({1'($urandom), body_len[27:21]});
            stream_q.push_back({1'($urandom), body_len[20:14]});
            stream_q.push_back({1'($urandom), body_len[13:7]});
            stream_q.push_back({1'($urandom), body_len[6:0]});
            repeat (body_len) stream_q.push_back(8'($urandom));
        end
        if ($urandom_range(3) == 0) begin
            stream_q.push_back(SYNC_BYTE);
            stream_q.push_back(sync_second());
            stream_q.push_back(8'($urandom));
            stream_q.push_back(bad_rate_byte());
        end
        stream_q.push_back(SYNC_BYTE);
        stream_q.push_back(sync_second());
        stream_q.push_back(8'($urandom));
        stream_q.push_back(good_rate_byte());
        repeat ($urandom_range(3)) stream_q.push_back(8'($urandom));
        if ($urandom_range(6) == 0) begin
            repeat ($urandom_range(stream_q.size() - 1)) void'(stream_q.pop_back());
        end
    endfunction

    task automatic run_random(input int idle_src, input int idle_sink, input bit last_phase);
        int start_count;
        src_idle_pct  = idle_src;
        sink_idle_pct = idle_sink;
        start_count   = bytes_sent;
        while (bytes_sent - start_count < PHASE_BYTES ||
               (last_phase && sb.produced < RESULT_TARGET)) begin
            build_stream();
            send_stream();
        end
        wait_drained();
    endtask

    initial begin : stimulus
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Unusable headers for each reason, then a good one, then a byte after lock.
        stream_q = '{SYNC_BYTE, SYNC_WITH_CRC, SYNC_BYTE, SYNC_WITH_CRC, SYNC_BYTE, 8'h04,
                     SYNC_BYTE, SYNC_NO_CRC, 8'h00, 8'h1C,
                     SYNC_BYTE, SYNC_WITH_CRC, 8'h00, 8'hEA, 8'h5A};
        send_stream();
        // A tag whose length is zero, followed at once by a header.
        stream_q = '{TAG_CHAR_I, TAG_CHAR_D, TAG_CHAR_3, 8'h04, 8'h00, 8'hFF,
                     8'h80, 8'h80, 8'h80, 8'h80,
                     SYNC_BYTE, SYNC_NO_CRC, 8'hFF, 8'h14};
        send_stream();
        wait_drained();

        run_random(29, 61, 1'b0);
        run_random(61, 29, 1'b0);

        // Hold the result channel so that the output stage fills and the input stalls.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request  = 400;
        repeat (12) begin
            stream_q = '{SYNC_BYTE, sync_second(), 8'($urandom), good_rate_byte()};
            send_stream();
        end
        wait_drained();

        run_random(0, 0, 1'b1);

        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("** mp3_frame_sync_finder: PASSED **");
        end else begin
            $display("** mp3_frame_sync_finder: FAILED **");
        end
        $finish;
    end

endmodule
